@@ rtl/core/jsld_pkg.sv @@
// Shared types, codes and constants of the JSON string literal decoder.
// Used by jsld_decode and json_string_literal_decoder_core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jsld_pkg;

	localparam int CP_W     = 21;
	localparam int LEN_W    = 24;
	localparam int HEX_W    = 16;
	localparam int HEXCNT_W = 2;
	localparam int HIGH_W   = 10;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd65536;

	localparam logic [CP_W-1:0] CP_QUOTE    = 21'h00022;
	localparam logic [CP_W-1:0] CP_BSLASH   = 21'h0005C;
	localparam logic [CP_W-1:0] CP_SLASH    = 21'h0002F;
	localparam logic [CP_W-1:0] CP_LETTER_B = 21'h00062;
	localparam logic [CP_W-1:0] CP_LETTER_F = 21'h00066;
	localparam logic [CP_W-1:0] CP_LETTER_N = 21'h0006E;
	localparam logic [CP_W-1:0] CP_LETTER_R = 21'h00072;
	localparam logic [CP_W-1:0] CP_LETTER_T = 21'h00074;
	localparam logic [CP_W-1:0] CP_LETTER_U = 21'h00075;
	localparam logic [CP_W-1:0] CP_CTRL_MAX = 21'h0001F;
	localparam logic [CP_W-1:0] CP_BS_CHAR  = 21'h00008;
	localparam logic [CP_W-1:0] CP_FF_CHAR  = 21'h0000C;
	localparam logic [CP_W-1:0] CP_LF_CHAR  = 21'h0000A;
	localparam logic [CP_W-1:0] CP_CR_CHAR  = 21'h0000D;
	localparam logic [CP_W-1:0] CP_TAB_CHAR = 21'h00009;
	localparam logic [CP_W-1:0] SUPP_BASE   = 21'h10000;

	// Top six bits of a 16-bit value inside the high and low surrogate ranges.
	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
	localparam logic [2:0] ERR_UNTERM    = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
	localparam logic [2:0] ERR_CONTROL   = 3'd3;
	localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
	localparam logic [2:0] ERR_NO_LOW    = 3'd5;
	localparam logic [2:0] ERR_BAD_LOW   = 3'd6;
	localparam logic [2:0] ERR_LONE_LOW  = 3'd7;

	typedef enum logic [6:0] {
		MODE_IDLE    = 7'b0000001,
		MODE_BODY    = 7'b0000010,
		MODE_ESC     = 7'b0000100,
		MODE_HEX1    = 7'b0001000,
		MODE_WANT_BS = 7'b0010000,
		MODE_WANT_U  = 7'b0100000,
		MODE_HEX2    = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            end_of_data;
	} item_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [CP_W-1:0] decoded_char;
		logic [2:0]      error_code;
	} result_t;

	typedef struct packed {
		mode_t               mode;
		logic [LEN_W-1:0]    len;
		logic [HEX_W-1:0]    hex_acc;
		logic [HEXCNT_W-1:0] hex_cnt;
		logic [HIGH_W-1:0]   high;
	} dec_state_t;

	localparam dec_state_t STATE_CLEAR = '{
		mode:    MODE_IDLE,
		len:     '0,
		hex_acc: '0,
		hex_cnt: '0,
		high:    '0
	};

	// True for the single-character escapes other than \u.
	function automatic logic is_simple_esc(input logic [CP_W-1:0] cp);
		logic hit;
		hit = (cp == CP_QUOTE) || (cp == CP_BSLASH) || (cp == CP_SLASH) ||
		      (cp == CP_LETTER_B) || (cp == CP_LETTER_F) || (cp == CP_LETTER_N) ||
		      (cp == CP_LETTER_R) || (cp == CP_LETTER_T);
		return hit;
	endfunction

	function automatic logic [CP_W-1:0] esc_char(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] ch;
		ch = cp;
		if (cp == CP_LETTER_B) ch = CP_BS_CHAR;
		else if (cp == CP_LETTER_F) ch = CP_FF_CHAR;
		else if (cp == CP_LETTER_N) ch = CP_LF_CHAR;
		else if (cp == CP_LETTER_R) ch = CP_CR_CHAR;
		else if (cp == CP_LETTER_T) ch = CP_TAB_CHAR;
		return ch;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsld_decode.sv @@
// Next-state and result logic for one code point of the string decoder.
// Purely combinational; depends on jsld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsld_decode
	import jsld_pkg::*;
(
	input  dec_state_t       st,
	input  item_t            item,
	input  logic [LEN_W-1:0] max_len,
	output dec_state_t       nxt,
	output logic             res_valid,
	output result_t          res
);

	logic [CP_W-1:0]  cp;
	logic             eod;
	logic [LEN_W:0]   len_inc;
	logic             hex_ok;
	logic [3:0]       hex_d;
	logic [HEX_W-1:0] acc_new;
	logic             fail;
	logic [2:0]       fail_code;
	logic             esc_emit;
	logic [CP_W-1:0]  esc_ch;

	assign cp      = item.code_point;
	assign eod     = item.end_of_data;
	assign len_inc = {1'b0, st.len} + {{LEN_W{1'b0}}, 1'b1};
	assign acc_new = {st.hex_acc[HEX_W-5:0], hex_d};

	always_comb begin
		hex_ok = 1'b0;
		hex_d  = cp[3:0];
		if (cp >= 21'h30 && cp <= 21'h39) begin
			hex_ok = 1'b1;
		end else if ((cp >= 21'h41 && cp <= 21'h46) || (cp >= 21'h61 && cp <= 21'h66)) begin
			hex_ok = 1'b1;
			hex_d  = cp[3:0] + 4'd9;
		end
	end

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		fail      = 1'b0;
		fail_code = ERR_NO_QUOTE;
		esc_emit  = 1'b0;
		esc_ch    = '0;

		unique case (st.mode)
			MODE_BODY: begin
				if (eod) begin
					fail = 1'b1; fail_code = ERR_UNTERM;
				end else if (cp <= CP_CTRL_MAX) begin
					fail = 1'b1; fail_code = ERR_CONTROL;
				end else if (cp == CP_QUOTE) begin
					nxt       = STATE_CLEAR;
					res_valid = 1'b1;
					res.kind  = KIND_CLOSE;
				end else if (cp == CP_BSLASH) begin
					nxt.mode = MODE_ESC;
				end else if (len_inc >= {1'b0, max_len}) begin
					// Reaching the limit exactly is already an error for plain text.
					fail = 1'b1; fail_code = ERR_TOO_LONG;
				end else begin
					nxt.len          = len_inc[LEN_W-1:0];
					res_valid        = 1'b1;
					res.kind         = KIND_CHAR;
					res.decoded_char = cp;
				end
			end
			MODE_ESC: begin
				if (eod) begin
					fail = 1'b1; fail_code = ERR_UNTERM;
				end else if (cp == CP_LETTER_U) begin
					nxt.mode    = MODE_HEX1;
					nxt.hex_acc = '0;
					nxt.hex_cnt = '0;
				end else if (is_simple_esc(cp)) begin
					esc_emit = 1'b1;
					esc_ch   = esc_char(cp);
				end else begin
					fail = 1'b1; fail_code = ERR_BAD_ESC;
				end
			end
			MODE_HEX1, MODE_HEX2: begin
				if (eod || !hex_ok) begin
					fail = 1'b1; fail_code = ERR_BAD_ESC;
				end else begin
					nxt.hex_acc = acc_new;
					if (st.hex_cnt != 2'd3) begin
						nxt.hex_cnt = st.hex_cnt + 2'd1;
					end else begin
						nxt.hex_cnt = '0;
						if (st.mode == MODE_HEX1) begin
							if (acc_new[15:10] == SURR_HIGH_TAG) begin
								nxt.high = acc_new[HIGH_W-1:0];
								nxt.mode = MODE_WANT_BS;
							end else if (acc_new[15:10] == SURR_LOW_TAG) begin
								fail = 1'b1; fail_code = ERR_LONE_LOW;
							end else begin
								esc_emit = 1'b1;
								esc_ch   = {{(CP_W-HEX_W){1'b0}}, acc_new};
							end
						end else if (acc_new[15:10] == SURR_LOW_TAG) begin
							esc_emit = 1'b1;
							esc_ch   = SUPP_BASE + {1'b0, st.high, acc_new[HIGH_W-1:0]};
						end else begin
							fail = 1'b1; fail_code = ERR_BAD_LOW;
						end
					end
				end
			end
			MODE_WANT_BS: begin
				if (eod || cp != CP_BSLASH) begin
					fail = 1'b1; fail_code = ERR_NO_LOW;
				end else begin
					nxt.mode = MODE_WANT_U;
				end
			end
			MODE_WANT_U: begin
				if (eod || cp != CP_LETTER_U) begin
					fail = 1'b1; fail_code = ERR_NO_LOW;
				end else begin
					nxt.mode    = MODE_HEX2;
					nxt.hex_acc = '0;
					nxt.hex_cnt = '0;
				end
			end
			default: begin
				if (eod || cp != CP_QUOTE) begin
					fail = 1'b1; fail_code = ERR_NO_QUOTE;
				end else begin
					nxt      = STATE_CLEAR;
					nxt.mode = MODE_BODY;
				end
			end
		endcase

		// Escaped characters may fill the string up to the limit itself.
		if (esc_emit) begin
			if (len_inc > {1'b0, max_len}) begin
				fail = 1'b1; fail_code = ERR_TOO_LONG;
			end else begin
				nxt.len          = len_inc[LEN_W-1:0];
				nxt.mode         = MODE_BODY;
				res_valid        = 1'b1;
				res.kind         = KIND_CHAR;
				res.decoded_char = esc_ch;
			end
		end

		if (fail) begin
			nxt            = STATE_CLEAR;
			res_valid      = 1'b1;
			res.kind       = KIND_ERROR;
			res.decoded_char = '0;
			res.error_code = fail_code;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/json_string_literal_decoder_core.sv @@
// A code point is registered on acceptance and decoded into the result register
// when that register is free or being emptied; the decode state updates with it.
// Throughput: one code point per cycle while the result register is not stalled.
// Reset: clears the decode state to idle, empties both stages and sets the length
// limit to 65536. Depends on jsld_pkg and jsld_decode.
`timescale 1ns / 1ps
`default_nettype none

module json_string_literal_decoder_core
	import jsld_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire item_t            item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output result_t               result
);

	logic             valid_s1;
	item_t            item_s1;
	logic             adv_s1;
	dec_state_t       state_q;
	dec_state_t       state_nxt;
	logic [LEN_W-1:0] max_len_q;
	logic             dec_valid;
	result_t          dec_res;
	logic             out_valid_q;
	result_t          out_q;

	// The registered code point is decoded when the result register is free
	// or is being emptied in the same cycle.
	assign adv_s1     = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;

	jsld_decode u_decode (
		.st        (state_q),
		.item      (item_s1),
		.max_len   (max_len_q),
		.nxt       (state_nxt),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= dec_valid;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && dec_valid) begin
			out_q <= dec_res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Input side stalls only while the first stage holds an item it cannot pass on.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && out_valid_q && !result_ready))
		else $error("input stalled without a blocked transaction in the first stage");

	// A close or an error transaction always returns the decoder to idle.
	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && dec_valid && dec_res.kind != KIND_CHAR) |=> (state_q.mode == MODE_IDLE))
		else $error("decoder not idle after close or error");

	// Only characters carry a code point, and only errors carry an error code.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.kind == KIND_CHAR && result.error_code == ERR_NO_QUOTE) ||
		                  (result.kind == KIND_CLOSE && result.decoded_char == '0 &&
		                   result.error_code == ERR_NO_QUOTE) ||
		                  (result.kind == KIND_ERROR && result.decoded_char == '0)))
		else $error("inconsistent result fields");

	// A result register that is stalled keeps its transaction.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(out_q)))
		else $error("stalled result transaction changed");

endmodule

`default_nettype wire

@@ bench/tb_json_string_literal_decoder_core.sv @@
// Self-checking testbench of json_string_literal_decoder_core: directed and random JSON strings
// against a cycle-free decoder model kept in the bench. Depends on jsld_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_json_string_literal_decoder_core;
	import jsld_pkg::*;

	localparam int IDLE_SETTLE    = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum int {
		FAULT_CONTROL,
		FAULT_EOD_BODY,
		FAULT_EOD_ESC,
		FAULT_BAD_ESC,
		FAULT_BAD_HEX,
		FAULT_NO_BSLASH,
		FAULT_NO_U,
		FAULT_BAD_LOW,
		FAULT_LONE_LOW,
		FAULT_BAD_HEX_LOW
	} fault_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	logic             item_valid;
	logic             item_ready;
	item_t            item;
	logic             result_valid;
	logic             result_ready;
	result_t          result;

	// Decoder model state.
	mode_t               str_mode  = MODE_IDLE;
	logic [LEN_W-1:0]    str_len   = '0;
	logic [HEX_W-1:0]    hex_acc   = '0;
	logic [HEXCNT_W-1:0] hex_cnt   = '0;
	logic [HIGH_W-1:0]   high_bits = '0;
	logic [LEN_W-1:0]    len_limit = MAX_LEN_RESET;

	result_t decoder_outcomes[$];
	int      mismatches   = 0;
	int      items_sent   = 0;
	int      quiet_cycles = 0;
	bit      send_calm    = 1'b0;
	bit      recv_calm    = 1'b0;

	json_string_literal_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- decoder model

	function automatic int hex_digit(input logic [CP_W-1:0] cp);
		if (cp >= 21'h30 && cp <= 21'h39) return int'(cp - 21'h30);
		if (cp >= 21'h41 && cp <= 21'h46) return int'(cp - 21'h41) + 10;
		if (cp >= 21'h61 && cp <= 21'h66) return int'(cp - 21'h61) + 10;
		return -1;
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [CP_W-1:0] ch,
			input logic [2:0] code);
		result_t r;
		r.kind         = kind;
		r.decoded_char = ch;
		r.error_code   = code;
		decoder_outcomes.push_back(r);
	endtask

	task automatic clear_string();
		str_mode  = MODE_IDLE;
		str_len   = '0;
		hex_acc   = '0;
		hex_cnt   = '0;
		high_bits = '0;
	endtask

	task automatic fail_string(input logic [2:0] code);
		clear_string();
		emit(KIND_ERROR, '0, code);
	endtask

	// Escaped characters may bring the length up to the limit itself.
	task automatic accept_escaped(input logic [CP_W-1:0] ch);
		if ({1'b0, str_len} + 25'd1 > {1'b0, len_limit}) begin
			fail_string(ERR_TOO_LONG);
		end else begin
			str_len  = str_len + 1'b1;
			str_mode = MODE_BODY;
			emit(KIND_CHAR, ch, '0);
		end
	endtask

	task automatic finish_hex();
		if (str_mode == MODE_HEX1) begin
			if (hex_acc[15:10] == SURR_HIGH_TAG) begin
				high_bits = hex_acc[9:0];
				str_mode  = MODE_WANT_BS;
			end else if (hex_acc[15:10] == SURR_LOW_TAG) begin
				fail_string(ERR_LONE_LOW);
			end else begin
				accept_escaped({5'd0, hex_acc});
			end
		end else if (hex_acc[15:10] == SURR_LOW_TAG) begin
			accept_escaped(SUPP_BASE + {1'b0, high_bits, hex_acc[9:0]});
		end else begin
			fail_string(ERR_BAD_LOW);
		end
	endtask

	task automatic decode_code_point(input item_t it);
		logic [CP_W-1:0] cp;
		int              digit;
		logic [3:0]      nib;
		cp = it.code_point;
		case (str_mode)
			MODE_BODY: begin
				if (it.end_of_data) fail_string(ERR_UNTERM);
				else if (cp <= CP_CTRL_MAX) fail_string(ERR_CONTROL);
				else if (cp == CP_QUOTE) begin
					clear_string();
					emit(KIND_CLOSE, '0, '0);
				end else if (cp == CP_BSLASH) begin
					str_mode = MODE_ESC;
				end else if ({1'b0, str_len} + 25'd1 >= {1'b0, len_limit}) begin
					fail_string(ERR_TOO_LONG);
				end else begin
					str_len = str_len + 1'b1;
					emit(KIND_CHAR, cp, '0);
				end
			end
			MODE_ESC: begin
				if (it.end_of_data) begin
					fail_string(ERR_UNTERM);
				end else begin
					case (cp)
						CP_QUOTE, CP_BSLASH, CP_SLASH: accept_escaped(cp);
						CP_LETTER_B: accept_escaped(CP_BS_CHAR);
						CP_LETTER_F: accept_escaped(CP_FF_CHAR);
						CP_LETTER_N: accept_escaped(CP_LF_CHAR);
						CP_LETTER_R: accept_escaped(CP_CR_CHAR);
						CP_LETTER_T: accept_escaped(CP_TAB_CHAR);
						CP_LETTER_U: begin
							str_mode = MODE_HEX1;
							hex_acc  = '0;
							hex_cnt  = '0;
						end
						default: fail_string(ERR_BAD_ESC);
					endcase
				end
			end
			MODE_HEX1, MODE_HEX2: begin
				digit = it.end_of_data ? -1 : hex_digit(cp);
				if (digit < 0) begin
					fail_string(ERR_BAD_ESC);
				end else begin
					nib     = digit[3:0];
					hex_acc = {hex_acc[11:0], nib};
					if (hex_cnt < 2'd3) begin
						hex_cnt = hex_cnt + 1'b1;
					end else begin
						hex_cnt = '0;
						finish_hex();
					end
				end
			end
			MODE_WANT_BS: begin
				if (it.end_of_data || cp != CP_BSLASH) fail_string(ERR_NO_LOW);
				else str_mode = MODE_WANT_U;
			end
			MODE_WANT_U: begin
				if (it.end_of_data || cp != CP_LETTER_U) begin
					fail_string(ERR_NO_LOW);
				end else begin
					str_mode = MODE_HEX2;
					hex_acc  = '0;
					hex_cnt  = '0;
				end
			end
			default: begin
				if (it.end_of_data || cp != CP_QUOTE) begin
					fail_string(ERR_NO_QUOTE);
				end else begin
					clear_string();
					str_mode = MODE_BODY;
				end
			end
		endcase
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (decoder_outcomes.size() == 0) begin
			report_mismatch("result with nothing expected", 32'(got), '0);
		end else begin
			want = decoder_outcomes.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 32'(got.kind), 32'(want.kind));
			if (got.decoded_char !== want.decoded_char)
				report_mismatch("decoded_char", 32'(got.decoded_char),
					32'(want.decoded_char));
			if (got.error_code !== want.error_code)
				report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) check_result(result);
			if (item_valid && item_ready) decode_code_point(item);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: a random stall before each transaction, with calm stretches.
	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, 12);
			repeat (stall) begin
				@(negedge clk);
				result_ready = 1'b0;
			end
			@(negedge clk);
			result_ready = 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- stimulus

	// Valid stays high after acceptance until the next falling edge decides.
	task automatic send_item(input logic [CP_W-1:0] cp, input logic eod);
		int gap;
		if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid       = 1'b1;
		item.code_point  = cp;
		item.end_of_data = eod;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [CP_W-1:0] random_cp();
		return CP_W'($urandom_range(0, 21'h1FFFFF));
	endfunction

	task automatic send_cp(input logic [CP_W-1:0] cp);
		send_item(cp, 1'b0);
	endtask

	task automatic send_eod();
		send_item(random_cp(), 1'b1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid = 1'b0;
		while (decoder_outcomes.size() != 0) @(posedge clk);
		// Items that yield nothing may still be inside the pipeline.
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic set_length_limit(input logic [LEN_W-1:0] limit);
		wait_idle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = limit;
		@(negedge clk);
		cfg_we    = 1'b0;
		len_limit = limit;
	endtask

	function automatic logic [CP_W-1:0] escape_letter(input int idx);
		case (idx)
			0: return CP_QUOTE;
			1: return CP_BSLASH;
			2: return CP_SLASH;
			3: return CP_LETTER_B;
			4: return CP_LETTER_F;
			5: return CP_LETTER_N;
			6: return CP_LETTER_R;
			default: return CP_LETTER_T;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 21'h30 + nib;
		if ($urandom_range(0, 1) != 0) return 21'h41 + nib - 4'd10;
		return 21'h61 + nib - 4'd10;
	endfunction

	function automatic logic [CP_W-1:0] plain_char();
		logic [CP_W-1:0] c;
		if ($urandom_range(0, 3) == 0) begin
			c = CP_W'($urandom_range(21'h7F, 21'h1FFFFF));
		end else begin
			c = CP_W'($urandom_range(21'h20, 21'h7E));
			if (c == CP_QUOTE || c == CP_BSLASH) c = 21'h41;
		end
		return c;
	endfunction

	function automatic logic [HEX_W-1:0] surrogate(input logic [5:0] tag);
		logic [9:0] low_bits;
		low_bits = 10'($urandom_range(0, 1023));
		return {tag, low_bits};
	endfunction

	task automatic send_unicode_escape(input logic [HEX_W-1:0] v);
		send_cp(CP_BSLASH);
		send_cp(CP_LETTER_U);
		for (int i = 3; i >= 0; i--) send_cp(hex_char(v[i*4 +: 4]));
	endtask

	task automatic send_bad_hex();
		logic [CP_W-1:0] c;
		repeat ($urandom_range(0, 3)) send_cp(hex_char(4'($urandom_range(0, 15))));
		if ($urandom_range(0, 2) == 0) begin
			send_eod();
		end else begin
			c = ($urandom_range(0, 1) != 0) ? CP_W'($urandom_range(21'h20, 21'h7E)) :
				random_cp();
			if (hex_digit(c) >= 0) c = 21'h67;
			send_cp(c);
		end
	endtask

	task automatic send_other_than(input logic [CP_W-1:0] avoid);
		logic [CP_W-1:0] c;
		if ($urandom_range(0, 2) == 0) begin
			send_eod();
		end else begin
			c = ($urandom_range(0, 1) != 0) ? CP_W'($urandom_range(21'h20, 21'h7E)) :
				random_cp();
			if (c == avoid) c = 21'h78;
			send_cp(c);
		end
	endtask

	task automatic send_element();
		logic [HEX_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: send_cp(plain_char());
			4, 5: begin
				send_cp(CP_BSLASH);
				send_cp(escape_letter($urandom_range(0, 7)));
			end
			6, 7: begin
				v = HEX_W'($urandom_range(0, 16'hFFFF));
				if (v[15:11] == 5'b11011) v[15] = 1'b0;
				send_unicode_escape(v);
			end
			default: begin
				send_unicode_escape(surrogate(SURR_HIGH_TAG));
				send_unicode_escape(surrogate(SURR_LOW_TAG));
			end
		endcase
	endtask

	task automatic send_fault(input fault_t f);
		logic [CP_W-1:0]  c;
		logic [HEX_W-1:0] v;
		case (f)
			FAULT_CONTROL: send_cp(CP_W'($urandom_range(0, CP_CTRL_MAX)));
			FAULT_EOD_BODY: send_eod();
			FAULT_EOD_ESC: begin
				send_cp(CP_BSLASH);
				send_eod();
			end
			FAULT_BAD_ESC: begin
				c = ($urandom_range(0, 3) == 0) ? random_cp() :
					CP_W'($urandom_range(21'h20, 21'h7E));
				if (c == CP_LETTER_U) c = 21'h71;
				for (int i = 0; i < 8; i++) if (c == escape_letter(i)) c = 21'h71;
				send_cp(CP_BSLASH);
				send_cp(c);
			end
			FAULT_BAD_HEX: begin
				send_cp(CP_BSLASH);
				send_cp(CP_LETTER_U);
				send_bad_hex();
			end
			FAULT_NO_BSLASH: begin
				send_unicode_escape(surrogate(SURR_HIGH_TAG));
				send_other_than(CP_BSLASH);
			end
			FAULT_NO_U: begin
				send_unicode_escape(surrogate(SURR_HIGH_TAG));
				send_cp(CP_BSLASH);
				send_other_than(CP_LETTER_U);
			end
			FAULT_BAD_LOW: begin
				v = HEX_W'($urandom_range(0, 16'hFFFF));
				if (v[15:10] == SURR_LOW_TAG) v[10] = 1'b0;
				send_unicode_escape(surrogate(SURR_HIGH_TAG));
				send_unicode_escape(v);
			end
			FAULT_LONE_LOW: send_unicode_escape(surrogate(SURR_LOW_TAG));
			default: begin
				send_unicode_escape(surrogate(SURR_HIGH_TAG));
				send_cp(CP_BSLASH);
				send_cp(CP_LETTER_U);
				send_bad_hex();
			end
		endcase
	endtask

	// Mostly well-formed strings; some end in a fault, a few are stray input while idle.
	task automatic send_random_string();
		int shape;
		int count;
		int fault_pos;
		shape = $urandom_range(0, 99);
		if (shape < 5) begin
			if ($urandom_range(0, 1) != 0) send_eod();
			else send_cp(random_cp());
		end else begin
			count     = $urandom_range(0, 8);
			fault_pos = (shape < 70) ? -1 : $urandom_range(0, count);
			send_cp(CP_QUOTE);
			for (int i = 0; i <= count; i++) begin
				if (i == fault_pos) begin
					send_fault(fault_t'($urandom_range(0, FAULT_BAD_HEX_LOW)));
					break;
				end
				if (i == count) send_cp(CP_QUOTE);
				else send_element();
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_idle_errors();
		send_item(21'h1FFFFF, 1'b1);
		send_cp(21'h78);
	endtask

	task automatic test_simple_escapes();
		send_cp(CP_QUOTE);
		for (int i = 0; i < 8; i++) begin
			send_cp(CP_BSLASH);
			send_cp(escape_letter(i));
		end
		send_cp(21'h1FFFFF);
		send_cp(21'h000000);
	endtask

	task automatic test_surrogate_pair();
		send_cp(CP_QUOTE);
		send_cp(CP_BSLASH);
		send_cp(CP_LETTER_U);
		send_cp(21'h64);
		send_cp(21'h42);
		send_cp(21'h66);
		send_cp(21'h46);
		send_cp(CP_BSLASH);
		send_cp(CP_LETTER_U);
		send_cp(21'h44);
		send_cp(21'h66);
		send_cp(21'h46);
		send_cp(21'h66);
		send_cp(CP_QUOTE);
	endtask

	task automatic test_length_limits();
		set_length_limit('0);
		send_cp(CP_QUOTE);
		send_cp(CP_QUOTE);
		send_cp(CP_QUOTE);
		send_cp(21'h61);
		// With a limit of two, an escape may reach the limit but a plain character may not.
		set_length_limit(24'd2);
		send_cp(CP_QUOTE);
		send_cp(21'h61);
		send_cp(CP_BSLASH);
		send_cp(CP_LETTER_N);
		send_cp(CP_QUOTE);
		send_cp(CP_QUOTE);
		send_cp(21'h61);
		send_cp(21'h62);
	endtask

	task automatic test_each_fault();
		set_length_limit(MAX_LEN_RESET);
		for (int f = FAULT_CONTROL; f <= FAULT_BAD_HEX_LOW; f++) begin
			send_cp(CP_QUOTE);
			send_element();
			send_fault(fault_t'(f));
		end
	endtask

	task automatic test_random_strings(input logic [LEN_W-1:0] limit, input int n_items);
		int target;
		set_length_limit(limit);
		target = items_sent + n_items;
		while (items_sent < target) send_random_string();
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		item_valid = 1'b0;
		item       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_errors();
		test_simple_escapes();
		test_surrogate_pair();
		test_length_limits();
		test_each_fault();
		test_random_strings(24'hFFFFFF, 110);
		test_random_strings(24'd3, 110);
		test_random_strings('0, 80);
		test_random_strings(24'd1, 80);
		test_random_strings(LEN_W'($urandom_range(2, 9)), 110);
		test_random_strings(MAX_LEN_RESET, 110);
		wait_idle();

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
